### rtl/core/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg - shared definitions for the depth pixel to world point unit
// Field widths, register indexes, reset values and pipeline control types.
// ----------------------------------------------------------------------------
package dpw_pkg;

    // Pixel coordinate handling: row and column are taken modulo 2^COORD_BITS
    localparam int COORD_BITS = 12;
    localparam int PIXEL_W    = 12;
    localparam logic [PIXEL_W-1:0] COORD_MASK = PIXEL_W'((1 << COORD_BITS) - 1);

    // Datapath widths
    localparam int DEPTH_W = 16;
    localparam int COEF_W  = 24;
    localparam int CENTER_W = 16;
    localparam int ZQ_W    = 32;   // unsigned Q16.16 metres
    localparam int RQ_W    = 29;   // signed Q.16 ray slope
    localparam int XQ_W    = 45;   // signed Q.16 metres
    localparam int ACC_W   = 64;   // signed Q.30 metres
    localparam int WORLD_W = 32;   // signed Q15.16 metres
    localparam int COLOR_W = 8;
    localparam int ROW_W   = 64;

    // Millimetres to Q.30 metres, 2^30/1000 rounded
    localparam logic signed [21:0] MM_TO_Q30 = 22'sd1073742;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z       = 3'd7;

    // Register reset values
    localparam logic [COEF_W-1:0]   RST_DEPTH_SCALE = 24'd16777;
    localparam logic [COEF_W-1:0]   RST_INV_FOCAL_X = 24'd31325;
    localparam logic [COEF_W-1:0]   RST_INV_FOCAL_Y = 24'd31317;
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = 16'd5079;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 16'd3760;
    localparam logic [ROW_W-1:0]    RST_ROW_X       = 64'h0000_0000_0000_4000;
    localparam logic [ROW_W-1:0]    RST_ROW_Y       = 64'h0000_0000_4000_0000;
    localparam logic [ROW_W-1:0]    RST_ROW_Z       = 64'h0000_4000_0000_0000;

    // Load enables for the transform stages
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

### rtl/core/depth_pixel_to_world_point_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_unit - depth pixel back-projection to world
// Back-projects a depth pixel through a pinhole model and carries it into
// the world frame with a 3x4 fixed-point rigid transform; colour passes.
//
//  channel  | direction | handshake            | contents
//  ---------+-----------+----------------------+-----------------------------
//  s_*      | in        | s_tvalid / s_tready  | row, col, depth, B, G, R
//  m_*      | out       | m_tvalid / m_tready  | world x, y, z, B, G, R
//  cfg_*    | in        | cfg_we (no wait)     | register index and data
//
// Five register stages: depth and slopes, camera point, products, sum,
// saturate. One request enters per cycle unless the output is stalled and the pipeline is full.
// Each stage holds its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles collapse and a stall loses nothing.
// Reset clears the valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata: pixel_row[11:0], pixel_col[23:12], raw_depth[39:24],
    //          blue[47:40], green[55:48], red[63:56]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,
    // m_tdata: world_x[31:0], world_y[63:32], world_z[95:64],
    //          out_blue[103:96], out_green[111:104], out_red[119:112]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [119:0]                     m_tdata,
    input  logic                             cfg_we,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpw_pkg::ROW_W-1:0]        cfg_data
);

    localparam int NSTG  = 5;
    localparam int RXP_W = 42;
    localparam int XP_W  = dpw_pkg::RQ_W + dpw_pkg::ZQ_W + 1;
    localparam int CLR_W = 3 * dpw_pkg::COLOR_W;

    // Configuration registers
    logic [dpw_pkg::COEF_W-1:0]   depth_scale_reg;
    logic [dpw_pkg::COEF_W-1:0]   inv_focal_x_reg;
    logic [dpw_pkg::COEF_W-1:0]   inv_focal_y_reg;
    logic [dpw_pkg::CENTER_W-1:0] center_x_reg;
    logic [dpw_pkg::CENTER_W-1:0] center_y_reg;
    logic [dpw_pkg::ROW_W-1:0]    row_x_reg;
    logic [dpw_pkg::ROW_W-1:0]    row_y_reg;
    logic [dpw_pkg::ROW_W-1:0]    row_z_reg;

    // Pipeline control
    logic [NSTG:1]     valid_reg;
    logic [NSTG+1:1]   en;
    dpw_pkg::stage_en_t axis_en;

    // Stage 1 signals
    logic [dpw_pkg::PIXEL_W-1:0]  row_m;
    logic [dpw_pkg::PIXEL_W-1:0]  col_m;
    logic [dpw_pkg::DEPTH_W-1:0]  depth;
    logic [dpw_pkg::DEPTH_W+dpw_pkg::COEF_W-1:0] zprod;
    logic signed [16:0]           dcol;
    logic signed [16:0]           drow;
    logic signed [RXP_W-1:0]      rxprod;
    logic signed [RXP_W-1:0]      ryprod;
    logic [dpw_pkg::ZQ_W-1:0]     zq1_next, zq1_reg;
    logic signed [dpw_pkg::RQ_W-1:0] rx1_next, rx1_reg;
    logic signed [dpw_pkg::RQ_W-1:0] ry1_next, ry1_reg;

    // Stage 2 signals
    logic signed [XP_W-1:0]       xprod;
    logic signed [XP_W-1:0]       yprod;
    logic signed [dpw_pkg::XQ_W-1:0] xq2_next, xq2_reg;
    logic signed [dpw_pkg::XQ_W-1:0] yq2_next, yq2_reg;
    logic [dpw_pkg::ZQ_W-1:0]     zq2_reg;

    // Colour pass-through line
    logic [CLR_W-1:0]             color_reg [1:NSTG];

    logic signed [dpw_pkg::WORLD_W-1:0] world_x;
    logic signed [dpw_pkg::WORLD_W-1:0] world_y;
    logic signed [dpw_pkg::WORLD_W-1:0] world_z;

    // Write configuration registers; unknown codes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_scale_reg <= dpw_pkg::RST_DEPTH_SCALE;
            inv_focal_x_reg <= dpw_pkg::RST_INV_FOCAL_X;
            inv_focal_y_reg <= dpw_pkg::RST_INV_FOCAL_Y;
            center_x_reg    <= dpw_pkg::RST_CENTER_X;
            center_y_reg    <= dpw_pkg::RST_CENTER_Y;
            row_x_reg       <= dpw_pkg::RST_ROW_X;
            row_y_reg       <= dpw_pkg::RST_ROW_Y;
            row_z_reg       <= dpw_pkg::RST_ROW_Z;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpw_pkg::REG_DEPTH_SCALE: depth_scale_reg <= cfg_data[dpw_pkg::COEF_W-1:0];
                dpw_pkg::REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[dpw_pkg::COEF_W-1:0];
                dpw_pkg::REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[dpw_pkg::COEF_W-1:0];
                dpw_pkg::REG_CENTER_X:    center_x_reg    <= cfg_data[dpw_pkg::CENTER_W-1:0];
                dpw_pkg::REG_CENTER_Y:    center_y_reg    <= cfg_data[dpw_pkg::CENTER_W-1:0];
                dpw_pkg::REG_ROW_X:       row_x_reg       <= cfg_data;
                dpw_pkg::REG_ROW_Y:       row_y_reg       <= cfg_data;
                dpw_pkg::REG_ROW_Z:       row_z_reg       <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Stage enables: load when empty or when the next stage moves
    always_comb
    begin
        en[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready   = en[1];
    assign axis_en.s3 = en[3];
    assign axis_en.s4 = en[4];
    assign axis_en.s5 = en[5];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: depth in metres and ray slopes
    assign row_m = s_tdata[11:0] & dpw_pkg::COORD_MASK;
    assign col_m = s_tdata[23:12] & dpw_pkg::COORD_MASK;
    assign depth = s_tdata[39:24];

    assign zprod    = {{dpw_pkg::COEF_W{1'b0}}, depth} * {{dpw_pkg::DEPTH_W{1'b0}}, depth_scale_reg};
    assign zq1_next = zprod[dpw_pkg::ZQ_W+7:8];

    assign dcol = $signed({1'b0, col_m, 4'b0000}) - $signed({1'b0, center_x_reg});
    assign drow = $signed({1'b0, row_m, 4'b0000}) - $signed({1'b0, center_y_reg});

    assign rxprod   = RXP_W'(dcol) * RXP_W'($signed({1'b0, inv_focal_x_reg}));
    assign ryprod   = RXP_W'(drow) * RXP_W'($signed({1'b0, inv_focal_y_reg}));
    assign rx1_next = rxprod[dpw_pkg::RQ_W+11:12];
    assign ry1_next = ryprod[dpw_pkg::RQ_W+11:12];

    // Stage 2: camera-frame x and y
    assign xprod    = XP_W'(rx1_reg) * XP_W'($signed({1'b0, zq1_reg}));
    assign yprod    = XP_W'(ry1_reg) * XP_W'($signed({1'b0, zq1_reg}));
    assign xq2_next = xprod[dpw_pkg::XQ_W+15:16];
    assign yq2_next = yprod[dpw_pkg::XQ_W+15:16];

    // Hold payload of the first two stages and the colour line
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            zq1_reg      <= zq1_next;
            rx1_reg      <= rx1_next;
            ry1_reg      <= ry1_next;
            color_reg[1] <= s_tdata[63:40];
        end
        if (en[2])
        begin
            xq2_reg <= xq2_next;
            yq2_reg <= yq2_next;
            zq2_reg <= zq1_reg;
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (en[k])
            begin
                color_reg[k] <= color_reg[k-1];
            end
        end
    end

    // Stages 3 to 5: one unit per world axis
    dpw_axis u_axis_x
    (
        .clk   (clk),
        .en    (axis_en),
        .row   (row_x_reg),
        .xq    (xq2_reg),
        .yq    (yq2_reg),
        .zq    (zq2_reg),
        .world (world_x)
    );

    dpw_axis u_axis_y
    (
        .clk   (clk),
        .en    (axis_en),
        .row   (row_y_reg),
        .xq    (xq2_reg),
        .yq    (yq2_reg),
        .zq    (zq2_reg),
        .world (world_y)
    );

    dpw_axis u_axis_z
    (
        .clk   (clk),
        .en    (axis_en),
        .row   (row_z_reg),
        .xq    (xq2_reg),
        .yq    (yq2_reg),
        .zq    (zq2_reg),
        .world (world_z)
    );

    // Drive the result request
    assign m_tvalid = valid_reg[NSTG];
    assign m_tdata  = {color_reg[NSTG], world_z, world_y, world_x};

endmodule

### rtl/core/dpw_axis.sv
// ----------------------------------------------------------------------------
// dpw_axis - one world axis of the rigid transform
// Multiplies one transform row into the camera point, sums, and saturates
// to signed Q15.16 over three register stages.
// ----------------------------------------------------------------------------
module dpw_axis
(
    input  logic                                clk,
    input  dpw_pkg::stage_en_t                  en,
    input  logic [dpw_pkg::ROW_W-1:0]           row,
    input  logic signed [dpw_pkg::XQ_W-1:0]     xq,
    input  logic signed [dpw_pkg::XQ_W-1:0]     yq,
    input  logic [dpw_pkg::ZQ_W-1:0]            zq,
    output logic signed [dpw_pkg::WORLD_W-1:0]  world
);

    localparam int PXY_W = dpw_pkg::XQ_W + 16;
    localparam int PZ_W  = dpw_pkg::ZQ_W + 17;
    localparam int PT_W  = 38;
    localparam int W_W   = dpw_pkg::ACC_W - 14;

    logic signed [15:0] r0;
    logic signed [15:0] r1;
    logic signed [15:0] r2;
    logic signed [15:0] t_mm;

    logic signed [PXY_W-1:0] px_next, px_reg;
    logic signed [PXY_W-1:0] py_next, py_reg;
    logic signed [PZ_W-1:0]  pz_next, pz_reg;
    logic signed [PT_W-1:0]  pt_next, pt_reg;
    logic signed [dpw_pkg::ACC_W-1:0] acc_next, acc_reg;
    logic signed [W_W-1:0]   w;
    logic signed [dpw_pkg::WORLD_W-1:0] world_next, world_reg;

    // Unpack the row: three Q2.14 coefficients and the translation
    assign r0   = $signed(row[15:0]);
    assign r1   = $signed(row[31:16]);
    assign r2   = $signed(row[47:32]);
    assign t_mm = $signed(row[63:48]);

    // Stage 3: form the four products
    assign px_next = PXY_W'(r0) * PXY_W'(xq);
    assign py_next = PXY_W'(r1) * PXY_W'(yq);
    assign pz_next = PZ_W'(r2) * PZ_W'($signed({1'b0, zq}));
    assign pt_next = PT_W'(t_mm) * PT_W'(dpw_pkg::MM_TO_Q30);

    // Stage 4: sum the products in Q.30
    assign acc_next = {{(dpw_pkg::ACC_W-PXY_W){px_reg[PXY_W-1]}}, px_reg}
                    + {{(dpw_pkg::ACC_W-PXY_W){py_reg[PXY_W-1]}}, py_reg}
                    + {{(dpw_pkg::ACC_W-PZ_W){pz_reg[PZ_W-1]}}, pz_reg}
                    + {{(dpw_pkg::ACC_W-PT_W){pt_reg[PT_W-1]}}, pt_reg};

    // Stage 5: drop to Q.16 and clamp to the 32-bit range
    assign w = acc_reg[dpw_pkg::ACC_W-1:14];

    always_comb
    begin
        if (w[W_W-1:dpw_pkg::WORLD_W-1] == '0 || w[W_W-1:dpw_pkg::WORLD_W-1] == '1)
        begin
            world_next = w[dpw_pkg::WORLD_W-1:0];
        end
        else if (w[W_W-1])
        begin
            world_next = {1'b1, {(dpw_pkg::WORLD_W-1){1'b0}}};
        end
        else
        begin
            world_next = {1'b0, {(dpw_pkg::WORLD_W-1){1'b1}}};
        end
    end

    // Advance each stage on its own enable
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            pt_reg <= pt_next;
        end
        if (en.s4)
        begin
            acc_reg <= acc_next;
        end
        if (en.s5)
        begin
            world_reg <= world_next;
        end
    end

    assign world = world_reg;

endmodule

### rtl/core/dpw_checker.sv
// ----------------------------------------------------------------------------
// dpw_checker - port-level checks for the depth pixel to world point unit
// Watches the stream ports for stall behavior, back-pressure and draining.
// ----------------------------------------------------------------------------
module dpw_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata
);

    logic idle_step;

    assign idle_step = !(s_tvalid && s_tready) && m_tready;

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // Hold stalled result data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Refuse input only when a result is waiting and the output is stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused with room in the pipeline");

    // Drain: free-flowing cycles with no input that empty every stage leave no result
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        idle_step ##1 idle_step ##1 idle_step ##1 idle_step ##1 idle_step
        |=> !m_tvalid)
        else $error("result appeared without a matching input");

endmodule

bind depth_pixel_to_world_point_unit dpw_checker u_dpw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
